FILE: hdl/lbr_pkg.sv
// Package for the Lehmer bit reservoir random source.
// Types, command codes and generator constants; no dependencies.
package lbr_pkg;

  localparam int unsigned STATE_W = 31;
  localparam int unsigned MULT_W  = 15;
  localparam int unsigned PROD_W  = STATE_W + MULT_W;
  localparam int unsigned STORE_W = 30;
  localparam int unsigned LEFT_W  = 5;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned BYTE_W  = 8;

  typedef logic [1:0]         cmd_t;
  typedef logic [STATE_W-1:0] lcg_t;

  localparam cmd_t CMD_RESEED = 2'd0;
  localparam cmd_t CMD_BIT    = 2'd1;
  localparam cmd_t CMD_BYTE   = 2'd2;

  localparam lcg_t               LCG_MOD      = 31'h7FFF_FFFF;
  localparam logic [MULT_W-1:0]  LCG_MULT     = 15'd16807;
  localparam lcg_t               SEED_MIX     = 31'h5A5A_5A5A;
  localparam lcg_t               SEED_FORCE   = 31'h0000_0002;
  localparam logic [LEFT_W-1:0]  STORE_BITS   = 5'd30;
  localparam logic [LEFT_W-1:0]  BYTE_BITS    = 5'd8;
  localparam logic [CNT_W-1:0]   RESEED_STEPS = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_FOLD,
    ST_DONE
  } lbr_state_t;

endpackage

FILE: hdl/lbr_if.sv
// Channel interfaces for the Lehmer bit reservoir random source.
// Depends on lbr_pkg for the payload types.
interface lbr_in_if;
  logic              valid;
  logic              ready;
  lbr_pkg::cmd_t     cmd;
  lbr_pkg::lcg_t     seed_value;

  modport source (output valid, output cmd, output seed_value, input ready);
  modport sink   (input valid, input cmd, input seed_value, output ready);
endinterface

interface lbr_out_if;
  logic                         valid;
  logic                         ready;
  logic [lbr_pkg::BYTE_W-1:0]   random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

FILE: hdl/lbr_step_unit.sv
// Shared generator step unit: x' = 16807 * x mod (2^31 - 1).
// Depends on lbr_pkg. Product is registered, then folded on the Mersenne modulus.
module lbr_step_unit (
  input  logic          clk,
  input  logic          load,
  input  lbr_pkg::lcg_t x_in,
  output lbr_pkg::lcg_t x_out
);

  logic [lbr_pkg::PROD_W-1:0]  prod_r;
  logic [lbr_pkg::PROD_W-1:0]  prod_nxt;
  logic [lbr_pkg::STATE_W:0]   fold_sum;

  // Form the product of the state and the multiplier
  always_comb begin
    prod_nxt = prod_r;
    if (load) begin
      prod_nxt = lbr_pkg::PROD_W'(x_in) * lbr_pkg::PROD_W'(lbr_pkg::LCG_MULT);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Fold high part onto low part, then one conditional subtract of the modulus
  always_comb begin
    fold_sum = (lbr_pkg::STATE_W+1)'(prod_r[lbr_pkg::PROD_W-1:lbr_pkg::STATE_W])
             + (lbr_pkg::STATE_W+1)'(prod_r[lbr_pkg::STATE_W-1:0]);
    if (fold_sum >= (lbr_pkg::STATE_W+1)'(lbr_pkg::LCG_MOD)) begin
      x_out = lbr_pkg::STATE_W'(fold_sum - (lbr_pkg::STATE_W+1)'(lbr_pkg::LCG_MOD));
    end else begin
      x_out = fold_sum[lbr_pkg::STATE_W-1:0];
    end
  end

endmodule

FILE: hdl/lehmer_bit_reservoir_rng_top.sv
// Top level of the Lehmer bit reservoir random source: sequencer, reservoir
// and output register. Depends on lbr_pkg, lbr_if and lbr_step_unit.
//
//  channel   dir  fields                   transfer when
//  in_ch     in   cmd, seed_value          in_ch.valid & in_ch.ready
//  out_ch    out  random_value             out_ch.valid & out_ch.ready
//
// A request served from the reservoir goes from IDLE straight to DONE, as does
// unused command code 3. A restock runs the generator through MUL and FOLD until
// bit 30 is clear, then goes to DONE; a reseed runs RESEED_STEPS generator steps.
// Each step uses the shared multiply-and-fold unit. Synchronous reset loads the
// state with 1 and empties the reservoir. A result waits in the output register
// while out_ch stalls; a further finished item holds in its last state until that frees.
module lehmer_bit_reservoir_rng_top (
  input  logic       clk,
  input  logic       rst_n,
  lbr_in_if.sink     in_ch,
  lbr_out_if.source  out_ch
);

  lbr_pkg::lbr_state_t                state_r, state_nxt;
  lbr_pkg::cmd_t                      cmd_r, cmd_nxt;
  lbr_pkg::lcg_t                      lehmer_r, lehmer_nxt;
  logic [lbr_pkg::STORE_W-1:0]        store_r, store_nxt;
  logic [lbr_pkg::LEFT_W-1:0]         left_r, left_nxt;
  logic [lbr_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [lbr_pkg::BYTE_W-1:0]         out_data_r, out_data_nxt;

  lbr_pkg::lcg_t                      seed_mix;
  lbr_pkg::lcg_t                      step_x;
  logic                               step_load;
  logic                               in_xfer;
  logic                               out_free;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Mix the seed; a mixed value equal to the modulus becomes 1
  always_comb begin
    seed_mix = (in_ch.seed_value ^ lbr_pkg::SEED_MIX) | lbr_pkg::SEED_FORCE;
    if (seed_mix == lbr_pkg::LCG_MOD) begin
      seed_mix = lbr_pkg::STATE_W'(1);
    end
  end

  lbr_step_unit u_step (
    .clk   (clk),
    .load  (step_load),
    .x_in  (lehmer_r),
    .x_out (step_x)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lbr_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          unique case (in_ch.cmd)
            lbr_pkg::CMD_RESEED: state_nxt = lbr_pkg::ST_MUL;
            lbr_pkg::CMD_BIT:
              state_nxt = (left_r == '0) ? lbr_pkg::ST_MUL : lbr_pkg::ST_DONE;
            lbr_pkg::CMD_BYTE:
              state_nxt = (left_r < lbr_pkg::BYTE_BITS) ? lbr_pkg::ST_MUL
                                                       : lbr_pkg::ST_DONE;
            default:             state_nxt = lbr_pkg::ST_DONE;
          endcase
        end
      end
      lbr_pkg::ST_MUL: state_nxt = lbr_pkg::ST_FOLD;
      lbr_pkg::ST_FOLD: begin
        if (cmd_r == lbr_pkg::CMD_RESEED) begin
          state_nxt = (cnt_r == lbr_pkg::CNT_W'(1)) ? lbr_pkg::ST_DONE : lbr_pkg::ST_MUL;
        end else begin
          state_nxt = step_x[lbr_pkg::STATE_W-1] ? lbr_pkg::ST_MUL : lbr_pkg::ST_DONE;
        end
      end
      lbr_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = lbr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lbr_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    cmd_nxt       = cmd_r;
    lehmer_nxt    = lehmer_r;
    store_nxt     = store_r;
    left_nxt      = left_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    step_load     = 1'b0;
    unique case (state_r)
      lbr_pkg::ST_IDLE: begin
        // take the command; a reseed loads the mixed seed and empties the reservoir
        if (in_xfer) begin
          cmd_nxt = in_ch.cmd;
          if (in_ch.cmd == lbr_pkg::CMD_RESEED) begin
            lehmer_nxt = seed_mix;
            cnt_nxt    = lbr_pkg::RESEED_STEPS;
            store_nxt  = '0;
            left_nxt   = '0;
          end
        end
      end
      lbr_pkg::ST_MUL: begin
        step_load = 1'b1;
      end
      lbr_pkg::ST_FOLD: begin
        // advance the generator; restock once bit 30 is clear
        lehmer_nxt = step_x;
        if (cmd_r == lbr_pkg::CMD_RESEED) begin
          cnt_nxt = cnt_r - lbr_pkg::CNT_W'(1);
        end else if (!step_x[lbr_pkg::STATE_W-1]) begin
          store_nxt = step_x[lbr_pkg::STORE_W-1:0];
          left_nxt  = lbr_pkg::STORE_BITS;
        end
      end
      lbr_pkg::ST_DONE: begin
        // draw from the low end of the reservoir into the output register
        if (out_free) begin
          out_valid_nxt = 1'b1;
          case (cmd_r)
            lbr_pkg::CMD_BIT: begin
              out_data_nxt = lbr_pkg::BYTE_W'(store_r[0]);
              store_nxt    = store_r >> 1;
              left_nxt     = left_r - lbr_pkg::LEFT_W'(1);
            end
            lbr_pkg::CMD_BYTE: begin
              out_data_nxt = store_r[lbr_pkg::BYTE_W-1:0];
              store_nxt    = store_r >> lbr_pkg::BYTE_W;
              left_nxt     = left_r - lbr_pkg::BYTE_BITS;
            end
            default: out_data_nxt = '0;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Hold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lbr_pkg::ST_IDLE;
      lehmer_r    <= lbr_pkg::STATE_W'(1);
      store_r     <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lehmer_r    <= lehmer_nxt;
      store_r     <= store_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ch.ready         = (state_r == lbr_pkg::ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.random_value = out_data_r;

endmodule
